// ===== rtl/core/sliding_window_band_power_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window band power block
// Concurrent checks are kept out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_BAND_POWER_ASSERT_SVH
`define SLIDING_WINDOW_BAND_POWER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SWBP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swbp check failed");
// Next-cycle implication, checked outside reset.
`define SWBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swbp check failed");
`else
`define SWBP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SWBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/swbp_pkg.sv =====
// ----------------------------------------------------------------------------
// swbp_pkg
// Shared constants, register codes and control structs of the band power block.
// ----------------------------------------------------------------------------
package swbp_pkg;

  // Default sizing
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MAX_TAPS_DEF     = 64;
  localparam int MAX_BANDS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CHANNEL_W   = 4;
  localparam int IN_SAMPLE_W = 16;
  localparam int BAND_IDX_W  = 3;
  localparam int TAP_IDX_W   = 6;
  localparam int COEF_W      = 16;
  localparam int COEF_FRAC   = 15;
  localparam int POWER_W     = 46;
  localparam int MAG_BITS    = 23;

  // Configuration registers
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 7;
  localparam int TAP_COUNT_W  = 7;
  localparam int BAND_COUNT_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_COUNT = 1'b1;
  localparam logic [TAP_COUNT_W-1:0]  TAP_COUNT_RESET  = 7'd26;
  localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RESET = 4'd3;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Drain states between the last tap read and the push of the band power
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = 2;

  typedef struct packed {
    logic issue;      // read one tap of the window and coefficient row
    logic first;      // first tap of a band: restart the accumulators
    logic push;       // load the output register with the band power
    logic last_band;  // pushed result closes the run
  } swbp_cmd_t;

  typedef struct packed {
    logic run_request;  // offered item is an in-range sample that ends a block
    logic out_free;     // output register can take a result this cycle
  } swbp_stat_t;

endpackage

// ===== rtl/core/swbp_stream_if.sv =====
// ----------------------------------------------------------------------------
// swbp_in_if / swbp_out_if
// Valid/ready channels for input items and band power results.
// ----------------------------------------------------------------------------
interface swbp_in_if import swbp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [CHANNEL_W-1:0]          channel;
  logic signed [IN_SAMPLE_W-1:0] sample_value;
  logic                          end_of_block;
  logic [BAND_IDX_W-1:0]         band_index;
  logic [TAP_IDX_W-1:0]          tap_index;
  logic signed [COEF_W-1:0]      coef_real;
  logic signed [COEF_W-1:0]      coef_imag;

  modport source (
    output valid, operation, channel, sample_value, end_of_block,
           band_index, tap_index, coef_real, coef_imag,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, sample_value, end_of_block,
           band_index, tap_index, coef_real, coef_imag,
    output ready
  );
endinterface

interface swbp_out_if import swbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHANNEL_W-1:0]  out_channel;
  logic [BAND_IDX_W-1:0] out_band;
  logic [POWER_W-1:0]    band_power;
  logic                  last_band;

  modport source (
    output valid, out_channel, out_band, band_power, last_band,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_band, band_power, last_band,
    output ready
  );
endinterface

// ===== rtl/core/swbp_ram.sv =====
// ----------------------------------------------------------------------------
// swbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/swbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// swbp_ctrl
// Configuration registers and the band/tap sequencer of the band power block.
// ----------------------------------------------------------------------------
`include "sliding_window_band_power_assert.svh"

module swbp_ctrl import swbp_pkg::*; #(
  parameter int MAX_TAPS  = MAX_TAPS_DEF,
  parameter int MAX_BANDS = MAX_BANDS_DEF,
  localparam int TAP_W    = $clog2(MAX_TAPS),
  localparam int BAND_W   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  swbp_stat_t             stat,
  output swbp_cmd_t              cmd,
  output logic [TAP_W-1:0]       tap,
  output logic [TAP_W-1:0]       age,
  output logic [BAND_W-1:0]      band
);

  localparam int TC_W = $clog2(MAX_TAPS + 1);
  localparam int BC_W = $clog2(MAX_BANDS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]              state, state_next;
  logic [TAP_COUNT_W-1:0]  tap_count;
  logic [BAND_COUNT_W-1:0] band_count;
  logic [TC_W-1:0]         tc_run, tc_clamp;
  logic [BC_W-1:0]         bc_run, bc_clamp;
  logic [TAP_W-1:0]        tap_next, age_next;
  logic [BAND_W-1:0]       band_next;
  logic [DRAIN_W-1:0]      drain_cnt, drain_cnt_next;
  logic                    start, last_tap;

  always_comb begin
    if (tap_count == '0) begin
      tc_clamp = TC_W'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      tc_clamp = TC_W'(MAX_TAPS);
    end else begin
      tc_clamp = TC_W'(tap_count);
    end
    if (band_count == '0) begin
      bc_clamp = BC_W'(1);
    end else if (int'(band_count) > MAX_BANDS) begin
      bc_clamp = BC_W'(MAX_BANDS);
    end else begin
      bc_clamp = BC_W'(band_count);
    end
  end

  assign in_ready      = (state == ST_IDLE);
  assign start         = in_valid && in_ready && stat.run_request;
  assign last_tap      = (TC_W'(tap) + TC_W'(1) == tc_run);
  assign cmd.issue     = (state == ST_RUN);
  assign cmd.first     = (tap == '0);
  assign cmd.push      = (state == ST_PUSH) && stat.out_free;
  assign cmd.last_band = (BC_W'(band) + BC_W'(1) == bc_run);

  always_comb begin
    state_next     = state;
    tap_next       = tap;
    age_next       = age;
    band_next      = band;
    drain_cnt_next = drain_cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          tap_next   = '0;
          age_next   = TAP_W'(tc_clamp - TC_W'(1));
          band_next  = '0;
        end
      end
      ST_RUN: begin
        tap_next = tap + TAP_W'(1);
        age_next = age - TAP_W'(1);
        if (last_tap) begin
          state_next     = ST_DRAIN;
          drain_cnt_next = DRAIN_W'(DRAIN_CYCLES - 1);
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = ST_PUSH;
        end else begin
          drain_cnt_next = drain_cnt - DRAIN_W'(1);
        end
      end
      ST_PUSH: begin
        // hold until the output register takes the result
        if (stat.out_free) begin
          if (cmd.last_band) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RUN;
            band_next  = band + BAND_W'(1);
            tap_next   = '0;
            age_next   = TAP_W'(tc_run - TC_W'(1));
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tap_count  <= TAP_COUNT_RESET;
      band_count <= BAND_COUNT_RESET;
      tc_run     <= '0;
      bc_run     <= '0;
      tap        <= '0;
      age        <= '0;
      band       <= '0;
      drain_cnt  <= '0;
    end else begin
      state     <= state_next;
      tap       <= tap_next;
      age       <= age_next;
      band      <= band_next;
      drain_cnt <= drain_cnt_next;
      if (start) begin
        tc_run <= tc_clamp;
        bc_run <= bc_clamp;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TAP_COUNT:  tap_count  <= cfg_data[TAP_COUNT_W-1:0];
          CFG_BAND_COUNT: band_count <= cfg_data[BAND_COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  `SWBP_ASSERT_NEXT(a_drain_to_push, clk, rst, (state == ST_DRAIN && drain_cnt == '0), (state == ST_PUSH))
  `SWBP_ASSERT_IMP(a_tap_in_window, clk, rst, cmd.issue, (TC_W'(tap) < tc_run && TC_W'(age) < tc_run))
  `SWBP_ASSERT_NEXT(a_last_push_idle, clk, rst, (cmd.push && cmd.last_band), (state == ST_IDLE))

endmodule

// ===== rtl/core/swbp_datapath.sv =====
// ----------------------------------------------------------------------------
// swbp_datapath
// Window and coefficient memories, complex MAC pipeline, power and output stage.
// ----------------------------------------------------------------------------
`include "sliding_window_band_power_assert.svh"

module swbp_datapath import swbp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int MAX_BANDS    = MAX_BANDS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  localparam int TAP_W       = $clog2(MAX_TAPS),
  localparam int BAND_W      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          operation,
  input  logic [CHANNEL_W-1:0]          channel,
  input  logic signed [IN_SAMPLE_W-1:0] sample_value,
  input  logic                          end_of_block,
  input  logic [BAND_IDX_W-1:0]         band_index,
  input  logic [TAP_IDX_W-1:0]          tap_index,
  input  logic signed [COEF_W-1:0]      coef_real,
  input  logic signed [COEF_W-1:0]      coef_imag,
  input  swbp_cmd_t                     cmd,
  input  logic [TAP_W-1:0]              tap,
  input  logic [TAP_W-1:0]              age,
  input  logic [BAND_W-1:0]             band,
  output swbp_stat_t                    stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHANNEL_W-1:0]          out_channel,
  output logic [BAND_IDX_W-1:0]         out_band,
  output logic [POWER_W-1:0]            band_power,
  output logic                          last_band
);

  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TC_W    = $clog2(MAX_TAPS + 1);
  localparam int POS_W   = TAP_W + 1;
  localparam int PROD_W  = SAMPLE_BITS + COEF_W;
  localparam int ACC_W   = SAMPLE_BITS + 2 + TAP_W;
  localparam int MAG_W   = (ACC_W > MAG_BITS + 1) ? ACC_W : MAG_BITS + 1;
  localparam int S_HI    = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int S_LO    = -(1 << (SAMPLE_BITS - 1));
  localparam logic [MAG_W-1:0]   MAG_LIMIT = MAG_W'(1) << MAG_BITS;
  localparam logic [POWER_W-1:0] POWER_MAX = '1;

  // Input side
  logic                   accept, ch_ok, load_ok, sample_acc, load_acc;
  logic [CH_W-1:0]        ch_idx;
  logic signed [31:0]     s_wide;
  logic [SAMPLE_BITS-1:0] s_clamp;
  logic [TAP_W-1:0]       wp [MAX_CHANNELS];
  logic [TC_W-1:0]        fill [MAX_CHANNELS];
  logic [TAP_W-1:0]       wp_cur, wp_adv;
  logic [TC_W-1:0]        fill_cur, fill_adv;
  logic [CH_W-1:0]        run_ch;
  logic [TAP_W-1:0]       run_wp;
  logic [TC_W-1:0]        run_fill;

  // Read side
  logic [POS_W-1:0]       pos_w, pos_a, pos_full;
  logic [TAP_W-1:0]       rd_pos;
  logic [SAMPLE_BITS-1:0] win_q;
  logic [2*COEF_W-1:0]    coef_q;

  // MAC pipeline
  logic                     v1, first1, zero1, v2, first2;
  logic signed [SAMPLE_BITS-1:0] x_op;
  logic signed [COEF_W-1:0] cr_op, ci_op;
  logic signed [PROD_W-1:0] prod_re, prod_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im;

  // Power stages
  logic [ACC_W-1:0]    mag_re, mag_im;
  logic [MAG_W-1:0]    mag_re_x, mag_im_x;
  logic [MAG_BITS-1:0] lo_re, lo_im;
  logic [POWER_W-1:0]  sq_re, sq_im, power;
  logic                over;
  logic [POWER_W:0]    sum;

  assign accept     = in_valid && in_ready;
  assign ch_ok      = int'(channel) < MAX_CHANNELS;
  assign load_ok    = int'(band_index) < MAX_BANDS && int'(tap_index) < MAX_TAPS;
  assign sample_acc = accept && (operation == OP_SAMPLE) && ch_ok;
  assign load_acc   = accept && (operation == OP_LOAD) && load_ok;
  assign ch_idx     = CH_W'(channel);

  assign stat.run_request = (operation == OP_SAMPLE) && ch_ok && end_of_block;
  assign stat.out_free    = !out_valid || out_ready;

  always_comb begin
    s_wide = 32'(sample_value);
    if (s_wide > S_HI) begin
      s_clamp = SAMPLE_BITS'(S_HI);
    end else if (s_wide < S_LO) begin
      s_clamp = SAMPLE_BITS'(S_LO);
    end else begin
      s_clamp = SAMPLE_BITS'(s_wide);
    end
  end

  // Circular window per channel: wp is the next slot, fill counts valid samples
  assign wp_cur   = wp[ch_idx];
  assign fill_cur = fill[ch_idx];
  assign wp_adv   = (int'(wp_cur) == MAX_TAPS - 1) ? '0 : wp_cur + TAP_W'(1);
  assign fill_adv = (int'(fill_cur) == MAX_TAPS) ? fill_cur : fill_cur + TC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wp[i]   <= '0;
        fill[i] <= '0;
      end
      run_ch   <= '0;
      run_wp   <= '0;
      run_fill <= '0;
    end else if (sample_acc) begin
      wp[ch_idx]   <= wp_adv;
      fill[ch_idx] <= fill_adv;
      run_ch       <= ch_idx;
      run_wp       <= wp_adv;
      run_fill     <= fill_adv;
    end
  end

  // Slot of the sample with the given age: newest sits just below run_wp
  assign pos_w    = POS_W'(run_wp);
  assign pos_a    = POS_W'(age) + POS_W'(1);
  assign pos_full = (pos_w >= pos_a) ? pos_w - pos_a : pos_w + POS_W'(MAX_TAPS) - pos_a;
  assign rd_pos   = TAP_W'(pos_full);

  swbp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << (CH_W + TAP_W))
  ) u_window_ram (
    .clk   (clk),
    .we    (sample_acc),
    .waddr ({ch_idx, wp_cur}),
    .wdata (s_clamp),
    .raddr ({run_ch, rd_pos}),
    .rdata (win_q)
  );

  swbp_ram #(
    .WIDTH (2 * COEF_W),
    .DEPTH (1 << (BAND_W + TAP_W))
  ) u_coef_ram (
    .clk   (clk),
    .we    (load_acc),
    .waddr ({BAND_W'(band_index), TAP_W'(tap_index)}),
    .wdata ({coef_real, coef_imag}),
    .raddr ({band, tap}),
    .rdata (coef_q)
  );

  // Samples older than the channel's fill count still read as zero
  assign x_op  = zero1 ? '0 : $signed(win_q);
  assign cr_op = $signed(coef_q[2*COEF_W-1:COEF_W]);
  assign ci_op = $signed(coef_q[COEF_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    first1  <= cmd.first;
    zero1   <= (TC_W'(age) >= run_fill);
    first2  <= first1;
    prod_re <= x_op * cr_op;
    prod_im <= x_op * ci_op;
    if (v2) begin
      acc_re <= (first2 ? '0 : acc_re) + ACC_W'(prod_re >>> COEF_FRAC);
      acc_im <= (first2 ? '0 : acc_im) + ACC_W'(prod_im >>> COEF_FRAC);
    end
  end

  assign mag_re   = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
  assign mag_im   = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);
  assign mag_re_x = MAG_W'(mag_re);
  assign mag_im_x = MAG_W'(mag_im);
  assign lo_re    = mag_re_x[MAG_BITS-1:0];
  assign lo_im    = mag_im_x[MAG_BITS-1:0];
  assign sum      = {1'b0, sq_re} + {1'b0, sq_im};

  // Free-running power stages follow the accumulators
  always_ff @(posedge clk) begin
    over  <= (mag_re_x >= MAG_LIMIT) || (mag_im_x >= MAG_LIMIT);
    sq_re <= lo_re * lo_re;
    sq_im <= lo_im * lo_im;
    power <= (over || sum > {1'b0, POWER_MAX}) ? POWER_MAX : sum[POWER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_channel <= CHANNEL_W'(run_ch);
      out_band    <= BAND_IDX_W'(band);
      band_power  <= power;
      last_band   <= cmd.last_band;
    end
  end

  `SWBP_ASSERT_IMP(a_push_drained, clk, rst, cmd.push, (!v1 && !v2))
  `SWBP_ASSERT_NEXT(a_push_loads_out, clk, rst, cmd.push, out_valid)
  `SWBP_ASSERT_NEXT(a_fill_grows, clk, rst, sample_acc, (run_fill != '0 && int'(run_fill) <= MAX_TAPS))

endmodule

// ===== rtl/core/sliding_window_band_power.sv =====
// ----------------------------------------------------------------------------
// sliding_window_band_power
// Per-channel sliding window short-time DFT bin power over loaded coefficients.
// ----------------------------------------------------------------------------
//  channel     dir  handshake          payload
//  item_in     in   valid/ready        operation, channel, sample, eob, coef load
//  result_out  out  valid/ready        out_channel, out_band, band_power, last_band
//  cfg         in   cfg_write          cfg_index, cfg_data (tap_count, band_count)
//
//  Sample items without end of block and load items are taken whenever idle.
//  An end-of-block sample starts a run over band_count bands of tap_count taps:
//  one shared complex MAC reads one tap per cycle, then a drain and a push.
//  item_in.ready drops while a run is in progress; a stalled result_out holds
//  the sequencer in its push step. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_band_power import swbp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int MAX_BANDS    = MAX_BANDS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  swbp_in_if.sink                item_in,
  swbp_out_if.source             result_out
);

  localparam int TAP_W  = $clog2(MAX_TAPS);
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  swbp_cmd_t         cmd;
  swbp_stat_t        stat;
  logic [TAP_W-1:0]  tap, age;
  logic [BAND_W-1:0] band;
  logic              ready;

  assign item_in.ready = ready;

  swbp_ctrl #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_BANDS (MAX_BANDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (item_in.valid),
    .in_ready  (ready),
    .stat      (stat),
    .cmd       (cmd),
    .tap       (tap),
    .age       (age),
    .band      (band)
  );

  swbp_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_TAPS     (MAX_TAPS),
    .MAX_BANDS    (MAX_BANDS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item_in.valid),
    .in_ready     (ready),
    .operation    (item_in.operation),
    .channel      (item_in.channel),
    .sample_value (item_in.sample_value),
    .end_of_block (item_in.end_of_block),
    .band_index   (item_in.band_index),
    .tap_index    (item_in.tap_index),
    .coef_real    (item_in.coef_real),
    .coef_imag    (item_in.coef_imag),
    .cmd          (cmd),
    .tap          (tap),
    .age          (age),
    .band         (band),
    .stat         (stat),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_channel  (result_out.out_channel),
    .out_band     (result_out.out_band),
    .band_power   (result_out.band_power),
    .last_band    (result_out.last_band)
  );

endmodule
